### design/envelope_peak_counter_unit_macros.svh
// Assertion macros used by the envelope peak counter top level.
`ifndef ENVELOPE_PEAK_COUNTER_UNIT_MACROS_SVH
`define ENVELOPE_PEAK_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/epc_pkg.sv
// Shared constants, types and command/status bundles of the envelope peak counter.
package epc_pkg;

	localparam int SMOOTH_LEN = 8;
	localparam int WINDOW_LEN = 500;

	localparam int SAMPLE_W = 10;
	localparam int FRAC_W   = 8;
	localparam int COUNT_W  = 8;
	localparam int IDX_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SUM_W    = $clog2(SMOOTH_LEN * 1023 + 1);
	localparam int RND_W    = SUM_W + 2;
	localparam int THR_W    = SAMPLE_W + FRAC_W;
	localparam int SMOOTH_DIV = 2 * SMOOTH_LEN;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(WINDOW_LEN - 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd1;

	localparam logic [FRAC_W-1:0] UPPER_RST = 8'd205;
	localparam logic [FRAC_W-1:0] LOWER_RST = 8'd128;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} epc_state_t;

	typedef struct packed {
		logic load_sample;
		logic smooth;
		logic walk_rd;
		logic finish;
	} epc_cmd_t;

	typedef struct packed {
		logic win_end;
		logic rd_last;
	} epc_stat_t;

endpackage

### design/envelope_peak_counter_unit.sv
// Top level of the envelope peak counter: config registers, controller and datapath.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------------
//  sample in | start, busy               | sample
//  result    | done (one-cycle strobe)   | smoothed, window_done, window_peak_value,
//            |                           | peak_total
//  config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// A sample beat that does not close a window passes the accept edge, then the
// smoothing state, whose edge loads the result; done rises the next cycle, when
// start may already be taken again.
// A sample that closes a window also runs a store walk, which reads one entry per
// cycle through the single read port of the window store.
// Reset clears the smoothing line, average, window index and peak; the store is not
// cleared, since the walk only reads entries written in the current window.
// The receiver cannot stall: each result beat is on the ports for exactly one cycle.
// cfg_ready is always high; write the registers only while the block is idle.
module envelope_peak_counter_unit import epc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [SAMPLE_W-1:0]  sample,
	output logic                 done,
	output logic [SAMPLE_W-1:0]  smoothed,
	output logic                 window_done,
	output logic [SAMPLE_W-1:0]  window_peak_value,
	output logic [COUNT_W-1:0]   peak_total,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAC_W-1:0]    cfg_data
);

`include "envelope_peak_counter_unit_macros.svh"

	epc_cmd_t          cmd;
	epc_stat_t         stat;
	logic [FRAC_W-1:0] upper_q;
	logic [FRAC_W-1:0] lower_q;

	assign cfg_ready = 1'b1;

	// Register file: writes beyond the two registers drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_RST;
			lower_q <= LOWER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_UPPER: upper_q <= cfg_data;
				CFG_LOWER: lower_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Sequencer: one smoothing step per beat, a store walk at window close.
	epc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Smoothing, window store, thresholds and the hysteresis counter.
	epc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.sample            (sample),
		.upper_frac        (upper_q),
		.lower_frac        (lower_q),
		.done              (done),
		.smoothed          (smoothed),
		.window_done       (window_done),
		.window_peak_value (window_peak_value),
		.peak_total        (peak_total)
	);

	// One result beat per sample: never two strobes back to back.
	`EPC_ASSERT_NXT(a_done_single, done, !done, "result strobe held two cycles")
	// An accepted sample never sees a stale strobe in the following cycle.
	`EPC_ASSERT_NXT(a_accept_quiet, start && !busy, !done && busy, "strobe after accept")
	// Window fields are zero unless the beat closes a window.
	`EPC_ASSERT_IMP(a_open_zero, done && !window_done,
		window_peak_value == '0 && peak_total == '0, "window fields set on open window")
	// A closing beat's window peak covers its own average.
	`EPC_ASSERT_IMP(a_wdone_peak, done && window_done, window_peak_value >= smoothed,
		"window peak below closing average")

endmodule

### design/epc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module epc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 500
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [WIDTH-1:0]              wdata,
	input  logic                          re,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/epc_ctrl.sv
// Controller state machine: sequences smoothing, the store walk and the window result.
module epc_ctrl import epc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  epc_stat_t stat,
	output epc_cmd_t  cmd,
	output logic      busy
);

	epc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				state_d = stat.win_end ? ST_WALK : ST_IDLE;
			end
			ST_WALK: begin
				if (stat.rd_last) state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy            = 1'b0;
				cmd.load_sample = start;
			end
			ST_SMOOTH: cmd.smooth  = 1'b1;
			ST_WALK:   cmd.walk_rd = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: cmd.finish  = 1'b1;
			default:   ;
		endcase
	end

endmodule

### design/epc_dp.sv
// Datapath: smoothing line, window store, peak tracking and hysteresis counter.
module epc_dp import epc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  epc_cmd_t            cmd,
	output epc_stat_t           stat,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [FRAC_W-1:0]   upper_frac,
	input  logic [FRAC_W-1:0]   lower_frac,
	output logic                done,
	output logic [SAMPLE_W-1:0] smoothed,
	output logic                window_done,
	output logic [SAMPLE_W-1:0] window_peak_value,
	output logic [COUNT_W-1:0]  peak_total
);

	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] line_q [SMOOTH_LEN];
	logic [SUM_W-1:0]    sum_q, sum_d;
	logic [SAMPLE_W-1:0] avg_q, avg_d;
	logic [RND_W-1:0]    rnd;
	logic                fill;
	logic [IDX_W-1:0]    idx_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic [IDX_W-1:0]    addr_q;
	logic                vld_s1;
	logic [SAMPLE_W-1:0] rdata;
	logic [THR_W-1:0]    hi_q, lo_q;
	logic [THR_W-1:0]    v_scaled;
	logic [COUNT_W-1:0]  count_q;
	logic                pend_q;
	logic                done_q;
	logic [SAMPLE_W-1:0] smoothed_q, wpeak_q;
	logic                wdone_q;
	logic [COUNT_W-1:0]  wcount_q;

	assign stat.win_end = (idx_q >= LAST_IDX);
	assign stat.rd_last = (addr_q == LAST_IDX);

	// Peak-hold: a sample above the last average floods the whole line.
	assign fill  = (sample_q > avg_q);
	assign sum_d = fill ? SUM_W'(SMOOTH_LEN) * SUM_W'(sample_q)
	                    : sum_q - SUM_W'(line_q[SMOOTH_LEN-1]) + SUM_W'(sample_q);
	assign rnd   = (RND_W'(sum_d) * RND_W'(2) + RND_W'(SMOOTH_LEN)) / RND_W'(SMOOTH_DIV);
	assign avg_d = rnd[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SMOOTH_LEN; i++) line_q[i] <= '0;
			sum_q  <= '0;
			avg_q  <= '0;
			idx_q  <= '0;
			peak_q <= '0;
		end else begin
			if (cmd.smooth) begin
				for (int i = 1; i < SMOOTH_LEN; i++) begin
					line_q[i] <= fill ? sample_q : line_q[i-1];
				end
				line_q[0] <= sample_q;
				sum_q     <= sum_d;
				avg_q     <= avg_d;
				idx_q     <= stat.win_end ? '0 : idx_q + 1'b1;
				if (avg_d > peak_q) peak_q <= avg_d;
			end
			if (cmd.finish) peak_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) sample_q <= sample;
	end

	epc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW_LEN)
	) u_store (
		.clk   (clk),
		.we    (cmd.smooth),
		.waddr (idx_q),
		.wdata (avg_d),
		.re    (cmd.walk_rd),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign v_scaled = {rdata, {FRAC_W{1'b0}}};

	// Walk: thresholds reload on every read, store data follows in the cycle after the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			vld_s1  <= 1'b0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			vld_s1 <= cmd.walk_rd;
			if (cmd.smooth) begin
				addr_q  <= '0;
				count_q <= '0;
				pend_q  <= 1'b0;
			end
			if (cmd.walk_rd) addr_q <= addr_q + 1'b1;
			if (vld_s1) begin
				if ((v_scaled > hi_q) && !pend_q && (count_q != COUNT_MAX)) begin
					count_q <= count_q + 1'b1;
				end
				if (v_scaled <= lo_q) begin
					pend_q <= 1'b0;
				end else if (v_scaled > hi_q) begin
					pend_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_rd) begin
			hi_q <= THR_W'(peak_q) * THR_W'(upper_frac);
			lo_q <= THR_W'(peak_q) * THR_W'(lower_frac);
		end
	end

	// Result registers: strobe for one cycle per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.smooth && !stat.win_end) || cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.smooth) begin
			smoothed_q <= avg_d;
			wdone_q    <= 1'b0;
			wpeak_q    <= '0;
			wcount_q   <= '0;
		end
		if (cmd.finish) begin
			smoothed_q <= avg_q;
			wdone_q    <= 1'b1;
			wpeak_q    <= peak_q;
			wcount_q   <= count_q;
		end
	end

	assign done              = done_q;
	assign smoothed          = smoothed_q;
	assign window_done       = wdone_q;
	assign window_peak_value = wpeak_q;
	assign peak_total        = wcount_q;

endmodule
